// File: sv/assert_macros.svh
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// File: sv/ses_pkg.sv
// Types and constants of the Sobel edge stream core.
package ses_pkg;

   localparam int SQ_W    = 12;  // gx*gx + gy*gy, at most 2*38*38
   localparam int RT_W    = 6;   // its square root
   localparam int WIDTH_W = 13;  // row width up to 4096
   localparam int RECIP_SHIFT = 20;

   localparam logic [18:0] RECIP_4   = 19'd262144;
   localparam logic [18:0] RECIP_10  = 19'd104858;
   localparam logic [18:0] RECIP_30  = 19'd34953;
   localparam logic [18:0] RECIP_200 = 19'd5243;

   localparam logic [1:0] MODE_HORIZ = 2'd0;
   localparam logic [1:0] MODE_VERT  = 2'd1;
   localparam logic [1:0] MODE_MAG   = 2'd2;
   localparam logic [1:0] MODE_PEAK  = 2'd3;

   localparam logic [1:0] REG_MODE      = 2'd0;
   localparam logic [1:0] REG_LARGE     = 2'd1;
   localparam logic [1:0] REG_THRESHOLD = 2'd2;
   localparam logic [1:0] REG_WIDTH     = 2'd3;

   localparam int K5X [5][5] = '{
      '{-1, -2, 0, 2, 1}, '{-2, -4, 0, 4, 2}, '{-4, -8, 0, 8, 4},
      '{-2, -4, 0, 4, 2}, '{-1, -2, 0, 2, 1}};
   localparam int K5Y [5][5] = '{
      '{-1, -2, -4, -2, -1}, '{-2, -4, -8, -4, -2}, '{0, 0, 0, 0, 0},
      '{2, 4, 8, 4, 2}, '{1, 2, 4, 2, 1}};
   localparam int K3X [3][3] = '{'{-1, 0, 1}, '{-1, 0, 1}, '{-1, 0, 1}};
   localparam int K3Y [3][3] = '{'{-1, -1, -1}, '{0, 0, 0}, '{1, 1, 1}};

   typedef enum logic [8:0] {
      ST_CLR  = 9'b000000001,
      ST_IDLE = 9'b000000010,
      ST_READ = 9'b000000100,
      ST_ROWS = 9'b000001000,
      ST_TOT  = 9'b000010000,
      ST_DIV  = 9'b000100000,
      ST_SQ   = 9'b001000000,
      ST_ROOT = 9'b010000000,
      ST_FIN  = 9'b100000000
   } state_type;

endpackage

// File: sv/sobel_edge_stream_core.sv
// Sobel edge stream core: top level with line memories, window and result logic.
// A pixel is taken only in the idle state, so a new pixel waits until the last one is written back.
// Steps: read, row sums, total, divide, root start, serial square root (six two-bit steps
// and the done flag) and the write-back, which waits while an earlier result is stalled,
// so the next pixel waits with it.
// Reset (synchronous) clears control state, then the clear state zeroes every line memory address.
`include "assert_macros.svh"
module sobel_edge_stream_core #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_KERNEL = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_pixel,
   input  logic        req_frame_start,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_value,
   output logic        rsp_row_end,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [10:0] csr_data
);
   import ses_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int MK = MAX_KERNEL;
   localparam int LW = (MK - 1) * 8;
   localparam int O3 = MK - 3;

   state_type state_ff, state_in;

   logic [1:0]  mode_ff;
   logic        large_ff;
   logic [7:0]  thr_ff;
   logic [10:0] lwidth_ff;

   logic [CW-1:0] column_ff, clr_ff;
   logic [11:0]   row_ff;
   logic [CW-1:0] item_col_ff;
   logic [11:0]   item_row_ff;
   logic [7:0]    pix_ff;
   logic          last_ff;

   logic [7:0] win_ff [MK][MK];
   logic [7:0] gw_ff [3][3];

   logic signed [15:0] px_ff [MK], py_ff [MK], px_in [MK], py_in [MK];
   logic signed [15:0] sx_ff, sy_ff, sx_in, sy_in;
   logic [5:0]         gx_ff, gy_ff;
   logic signed [10:0] qv_ff;
   logic [SQ_W-1:0]    sumsq_ff, sumsq_in;
   logic [7:0]         mag_ff;
   logic               sq_done;
   logic [RT_W-1:0]    sq_root;

   logic                acc;
   logic [CW-1:0]       col_eff;
   logic [11:0]         row_eff;
   logic [WIDTH_W-1:0]  w_eff;
   logic                last_in;
   logic                k5;

   logic          pl_we, pl_re, gl_we;
   logic [CW-1:0] pl_waddr, gl_waddr;
   logic [LW-1:0] pl_wdata, pl_rdata;
   logic [15:0]   gl_wdata, gl_rdata;

   logic          rsp_valid_ff;
   logic [7:0]    rsp_value_ff;
   logic          rsp_row_end_ff;
   logic          emit;
   logic [7:0]    val;
   logic          advance;
   logic [2:0]    kmin;

   assign k5 = large_ff && (MK >= 5);
   assign kmin = k5 ? 3'd4 : 3'd2;
   assign acc = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   assign col_eff = req_frame_start ? '0 : column_ff;
   assign row_eff = req_frame_start ? '0 : row_ff;

   always_comb begin
      w_eff = {2'b00, lwidth_ff};
      if (w_eff < WIDTH_W'(8)) begin
         w_eff = WIDTH_W'(8);
      end
      if (w_eff > WIDTH_W'(MAX_WIDTH)) begin
         w_eff = WIDTH_W'(MAX_WIDTH);
      end
      last_in = WIDTH_W'(col_eff) >= (w_eff - WIDTH_W'(1));
   end

   // line memories: pixel rows packed one column per word, gradient rows likewise
   ses_ram #(.WIDTH(LW), .DEPTH(MAX_WIDTH)) u_pixel_lines (
      .clock(clock), .we(pl_we), .waddr(pl_waddr), .wdata(pl_wdata),
      .re(pl_re), .raddr(col_eff), .rdata(pl_rdata));

   ses_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH)) u_gradient_lines (
      .clock(clock), .we(gl_we), .waddr(gl_waddr), .wdata(gl_wdata),
      .re(pl_re), .raddr(col_eff), .rdata(gl_rdata));

   ses_isqrt u_isqrt (
      .clock(clock), .reset(reset), .start(state_ff == ST_SQ),
      .operand(sumsq_in), .done(sq_done), .root(sq_root));

   assign pl_re = acc;

   always_comb begin
      pl_we    = 1'b0;
      pl_waddr = item_col_ff;
      pl_wdata = {pl_rdata[LW-9:0], pix_ff};
      gl_we    = 1'b0;
      gl_waddr = item_col_ff;
      gl_wdata = {gl_rdata[7:0], mag_ff};
      if (state_ff == ST_CLR) begin
         pl_we    = 1'b1;
         pl_waddr = clr_ff;
         pl_wdata = '0;
         gl_we    = 1'b1;
         gl_waddr = clr_ff;
         gl_wdata = '0;
      end else if (state_ff == ST_READ) begin
         pl_we = 1'b1;
      end else if (state_ff == ST_FIN) begin
         gl_we = advance;
      end
   end

   // row partial sums of both kernels
   always_comb begin
      int ax, ay;
      for (int y = 0; y < MK; y++) begin
         ax = 0;
         ay = 0;
         if (k5) begin
            for (int x = 0; x < MK; x++) begin
               ax = ax + int'(win_ff[y][x]) * K5X[y][x];
               ay = ay + int'(win_ff[y][x]) * K5Y[y][x];
            end
         end else if (y >= O3) begin
            for (int x = 0; x < 3; x++) begin
               ax = ax + int'(win_ff[y][O3+x]) * K3X[y-O3][x];
               ay = ay + int'(win_ff[y][O3+x]) * K3Y[y-O3][x];
            end
         end
         px_in[y] = 16'(ax);
         py_in[y] = 16'(ay);
      end
   end

   always_comb begin
      sx_in = '0;
      sy_in = '0;
      for (int y = 0; y < MK; y++) begin
         sx_in = sx_in + px_ff[y];
         sy_in = sy_in + py_ff[y];
      end
   end

   // division by constants via reciprocal multiply on magnitudes
   logic [12:0] abs_x, abs_y, abs_v;
   logic [18:0] rg, rv;
   logic [31:0] prod_x, prod_y, prod_v;
   logic signed [15:0] sel_v;
   always_comb begin
      sel_v  = (mode_ff == MODE_HORIZ) ? sx_ff : sy_ff;
      abs_x  = sx_ff[15] ? 13'(-sx_ff) : 13'(sx_ff);
      abs_y  = sy_ff[15] ? 13'(-sy_ff) : 13'(sy_ff);
      abs_v  = sel_v[15] ? 13'(-sel_v) : 13'(sel_v);
      rg     = k5 ? RECIP_200 : RECIP_30;
      rv     = k5 ? RECIP_10 : RECIP_4;
      prod_x = 32'(abs_x) * 32'(rg);
      prod_y = 32'(abs_y) * 32'(rg);
      prod_v = 32'(abs_v) * 32'(rv);
   end

   assign sumsq_in = SQ_W'({6'b0, gx_ff} * {6'b0, gx_ff}) +
                     SQ_W'({6'b0, gy_ff} * {6'b0, gy_ff});

   // gradient window shift and result selection
   logic [7:0]         g_c, g_up, g_dn, g_lf, g_rt;
   logic signed [12:0] biased;
   always_comb begin
      g_c    = gw_ff[1][2];
      g_up   = gw_ff[0][2];
      g_dn   = gw_ff[2][2];
      g_lf   = gw_ff[1][1];
      g_rt   = gl_rdata[7:0];
      biased = 13'(qv_ff) + 13'sd128;
      emit   = 1'b0;
      val    = '0;
      if (mode_ff != MODE_PEAK) begin
         emit = (item_row_ff >= 12'(kmin)) && (CW'(kmin) <= item_col_ff);
         if (mode_ff == MODE_MAG) begin
            val = mag_ff;
         end else if (biased < 0) begin
            val = 8'd0;
         end else if (biased > 13'sd255) begin
            val = 8'd255;
         end else begin
            val = biased[7:0];
         end
      end else begin
         emit = (item_row_ff >= 12'(kmin + 3'd2)) && (CW'(kmin + 3'd2) <= item_col_ff);
         if ((g_c > g_up && g_c >= g_dn && g_c > thr_ff) ||
             (g_c > g_lf && g_c >= g_rt && g_c > thr_ff)) begin
            val = 8'd255;
         end
      end
      advance = !(emit && rsp_valid_ff && rsp_stall);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLR:  if (clr_ff == CW'(MAX_WIDTH - 1)) state_in = ST_IDLE;
         ST_IDLE: if (acc) state_in = ST_READ;
         ST_READ: state_in = ST_ROWS;
         ST_ROWS: state_in = ST_TOT;
         ST_TOT:  state_in = ST_DIV;
         ST_DIV:  state_in = ST_SQ;
         ST_SQ:   state_in = ST_ROOT;
         ST_ROOT: if (sq_done) state_in = ST_FIN;
         ST_FIN:  if (advance) state_in = ST_IDLE;
         default: state_in = ST_CLR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         clr_ff       <= '0;
         mode_ff      <= MODE_HORIZ;
         large_ff     <= 1'b0;
         thr_ff       <= 8'd120;
         lwidth_ff    <= 11'd500;
         column_ff    <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int y = 0; y < MK; y++) begin
            for (int x = 0; x < MK; x++) begin
               win_ff[y][x] <= '0;
            end
         end
         for (int y = 0; y < 3; y++) begin
            for (int x = 0; x < 3; x++) begin
               gw_ff[y][x] <= '0;
            end
         end
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLR) begin
            clr_ff <= clr_ff + CW'(1);
         end
         if (csr_valid) begin
            case (csr_index)
               REG_MODE:      mode_ff   <= csr_data[1:0];
               REG_LARGE:     large_ff  <= csr_data[0];
               REG_THRESHOLD: thr_ff    <= csr_data[7:0];
               REG_WIDTH:     lwidth_ff <= csr_data;
               default:       mode_ff   <= mode_ff;
            endcase
         end
         if (acc) begin
            if (last_in) begin
               column_ff <= '0;
               row_ff    <= (row_eff == 12'd4095) ? row_eff : row_eff + 12'd1;
            end else begin
               column_ff <= col_eff + CW'(1);
               row_ff    <= row_eff;
            end
         end
         if (state_ff == ST_READ) begin
            for (int y = 0; y < MK; y++) begin
               for (int x = 0; x < MK - 1; x++) begin
                  win_ff[y][x] <= win_ff[y][x+1];
               end
            end
            win_ff[MK-1][MK-1] <= pix_ff;
            for (int i = 0; i < MK - 1; i++) begin
               win_ff[MK-2-i][MK-1] <= pl_rdata[i*8 +: 8];
            end
         end
         if (state_ff == ST_FIN && advance) begin
            for (int y = 0; y < 3; y++) begin
               gw_ff[y][0] <= gw_ff[y][1];
               gw_ff[y][1] <= gw_ff[y][2];
            end
            gw_ff[2][2] <= mag_ff;
            gw_ff[1][2] <= gl_rdata[7:0];
            gw_ff[0][2] <= gl_rdata[15:8];
         end
         // a new beat may replace one taken at this same edge
         if (state_ff == ST_FIN && advance && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (acc) begin
         item_col_ff <= col_eff;
         item_row_ff <= row_eff;
         pix_ff      <= req_pixel;
         last_ff     <= last_in;
      end
      if (state_ff == ST_ROWS) begin
         px_ff <= px_in;
         py_ff <= py_in;
      end
      if (state_ff == ST_TOT) begin
         sx_ff <= sx_in;
         sy_ff <= sy_in;
      end
      if (state_ff == ST_DIV) begin
         gx_ff <= 6'(prod_x >> RECIP_SHIFT);
         gy_ff <= 6'(prod_y >> RECIP_SHIFT);
         qv_ff <= sel_v[15] ? -11'(prod_v >> RECIP_SHIFT) : 11'(prod_v >> RECIP_SHIFT);
      end
      if (state_ff == ST_SQ) begin
         sumsq_ff <= sumsq_in;
      end
      if (state_ff == ST_ROOT && sq_done) begin
         mag_ff <= 8'(sq_root);
      end
      if (state_ff == ST_FIN && advance && emit) begin
         rsp_value_ff   <= val;
         rsp_row_end_ff <= last_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_value   = rsp_value_ff;
   assign rsp_row_end = rsp_row_end_ff;

   `ASSERT_ALWAYS(a_root_floor, clock, reset, !sq_done || ((13'(sq_root) * 13'(sq_root) <= 13'(sumsq_ff)) && (13'(sumsq_ff) < (13'(sq_root) + 13'd1) * (13'(sq_root) + 13'd1))), "square root not floor")
   `ASSERT_NEXT(a_accept_read, clock, reset, req_valid && !req_stall, state_ff == ST_READ, "accepted beat not followed by memory read")
   `ASSERT_ALWAYS(a_result_src, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN), "result raised outside final step")
endmodule

// File: sv/ses_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ses_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// File: sv/ses_isqrt.sv
// Serial floor square root, two operand bits per cycle.
module ses_isqrt (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [ses_pkg::SQ_W-1:0]  operand,
   output logic                      done,
   output logic [ses_pkg::RT_W-1:0]  root
);
   import ses_pkg::*;

   logic [SQ_W-1:0] rem_ff, rem_in, root_ff, root_in, bit_ff, bit_in;
   logic            busy_ff, busy_in, done_ff, done_in;
   logic [SQ_W:0]   trial;

   always_comb begin
      trial   = {1'b0, root_ff} + {1'b0, bit_ff};
      rem_in  = rem_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = operand;
         root_in = '0;
         bit_in  = SQ_W'(1) << (SQ_W - 2);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if ({1'b0, rem_ff} >= trial) begin
            rem_in  = rem_ff - trial[SQ_W-1:0];
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff == SQ_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
   end

   assign done = done_ff;
   assign root = root_ff[RT_W-1:0];
endmodule
